>>> hdl/assert_macros.svh
// Assertion macros used by the bucketed key multiset RTL.
// Self-contained; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted (active low).
`define BKM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds during reset.
`define BKM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/bkm_pkg.sv
// Shared types and constants of the bucketed key multiset.
// No dependencies; imported by every module of the block.
package bkm_pkg;

    localparam int KEY_BITS = 64;
    localparam int CNT_W    = 4;
    localparam int OUT_W    = 8;
    localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_COUNT  = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_HASH,
        S_DISPATCH,
        S_SCAN,
        S_MOVE_RD,
        S_MOVE_WR,
        S_CLEAR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic fill_rd;
        logic ins_wr;
        logic scan_init;
        logic scan;
        logic move_rd;
        logic move_wr;
        logic sweep;
        logic res_load;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic mod_done;
        logic fill_full;
        logic scan_end;
        logic found;
        logic out_free;
        logic sweep_last;
    } t_dp_sts;

endpackage

>>> hdl/bkm_mod.sv
// Bucket index unit: key modulo BUCKETS.
// Power-of-two bucket counts take the low key bits; others fold 16-bit key chunks
// through a reciprocal multiply, in a multiply step and a remainder step per chunk.
module bkm_mod #(
    parameter int BUCKETS   = 1024,
    parameter int KEY_WIDTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [KEY_WIDTH-1:0]       i_key,
    output logic                       o_done,
    output logic [$clog2(BUCKETS)-1:0] o_bucket
);
    import bkm_pkg::*;

    localparam int  BW      = $clog2(BUCKETS);
    localparam bit  IS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

    logic [BW-1:0] r_rem;
    logic          r_done;

    assign o_done   = r_done;
    assign o_bucket = r_rem;

    generate
        if (IS_POW2) begin : g_pow2
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else if (i_start) begin
                    r_done <= 1'b1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_rem <= i_key[BW-1:0];
                end
            end
        end else begin : g_recip
            // Horner over 16-bit chunks, most significant first:
            // rem = (rem * 2^16 + chunk) mod BUCKETS. The quotient of each step
            // comes from an exact reciprocal multiply, the remainder in the following cycle.
            localparam int CH  = 16;
            localparam int NC  = (KEY_WIDTH + CH - 1) / CH;
            localparam int PKW = NC * CH;
            localparam int XW  = BW + CH;
            localparam int SH  = XW + BW;
            localparam int MW  = XW + 1;
            localparam int PW  = XW + MW;
            localparam int CW  = $clog2(NC + 1);
            localparam logic [63:0]   RECIP64 = ((64'd1 << SH) / 64'(BUCKETS)) + 64'd1;
            localparam logic [MW-1:0] RECIP   = RECIP64[MW-1:0];

            logic [PKW-1:0]   r_sh;
            logic [CW-1:0]    r_left;
            logic             r_phase;
            logic [XW-1:0]    r_x;
            logic [PW-SH-1:0] r_q;
            logic [XW-1:0]    x;
            logic [PW-1:0]    prod;
            logic [XW-1:0]    qb;
            logic [XW-1:0]    diff;

            always_comb begin
                x    = {r_rem, r_sh[PKW-1 -: CH]};
                prod = PW'(x) * PW'(RECIP);
                qb   = XW'(r_q) * XW'(BUCKETS);
                diff = r_x - qb;
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_left  <= '0;
                    r_phase <= 1'b0;
                    r_done  <= 1'b0;
                end else if (i_start) begin
                    r_left  <= CW'(NC);
                    r_phase <= 1'b0;
                    r_done  <= 1'b0;
                end else if (r_left != '0) begin
                    r_phase <= !r_phase;
                    if (r_phase) begin
                        r_left <= r_left - CW'(1);
                        if (r_left == CW'(1)) begin
                            r_done <= 1'b1;
                        end
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_rem <= '0;
                    r_sh  <= PKW'(i_key);
                end else if (r_left != '0) begin
                    if (!r_phase) begin
                        r_x <= x;
                        r_q <= prod[PW-1:SH];
                    end else begin
                        r_rem <= diff[BW-1:0];
                        r_sh  <= r_sh << CH;
                    end
                end
            end
        end
    endgenerate

endmodule

>>> hdl/bkm_dpath.sv
// Datapath of the bucketed key multiset: fill and key memories, scan compare, result register.
// Depends on bkm_pkg, bkm_mod and assert_macros.svh.
`include "assert_macros.svh"

module bkm_dpath #(
    parameter int BUCKETS      = 1024,
    parameter int BUCKET_DEPTH = 8,
    parameter int KEY_WIDTH    = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bkm_pkg::t_dp_cmd             i_cmd,
    output bkm_pkg::t_dp_sts             o_sts,
    input  bkm_pkg::t_op                 i_op,
    input  logic [bkm_pkg::KEY_BITS-1:0] i_key,
    input  logic                         i_m_tready,
    output logic                         o_m_tvalid,
    output bkm_pkg::t_status             o_status,
    output logic [bkm_pkg::CNT_W-1:0]    o_match_count
);
    import bkm_pkg::*;

    localparam int FW = $clog2(BUCKET_DEPTH + 1);
    localparam int IW = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam int BW = $clog2(BUCKETS);
    localparam int KD = BUCKETS * BUCKET_DEPTH;
    localparam int AW = $clog2(KD);

    logic [FW-1:0]        fill_mem [BUCKETS];
    logic [KEY_WIDTH-1:0] key_mem  [KD];

    t_op                  r_op;
    logic [KEY_WIDTH-1:0] r_key;
    logic [AW-1:0]        r_base;
    logic [FW-1:0]        r_fill_q;
    logic [KEY_WIDTH-1:0] r_key_q;
    logic [FW-1:0]        r_idx;
    logic                 r_cmp_vld;
    logic [IW-1:0]        r_cmp_idx;
    logic [IW-1:0]        r_pos;
    logic                 r_found;
    logic [CNT_W-1:0]     r_cnt;
    logic [BW-1:0]        r_sweep;
    logic                 r_out_vld;
    t_status              r_out_status;
    logic [CNT_W-1:0]     r_out_cnt;

    logic                 mod_done;
    logic [BW-1:0]        mod_bkt;
    logic                 fill_full;
    logic [FW-1:0]        fill_inc;
    logic [FW-1:0]        fill_dec;
    logic                 hit;
    logic                 scan_issue;
    logic                 scan_end;
    logic                 sweep_last;
    logic                 out_free;
    logic                 key_rd_en;
    logic [AW-1:0]        key_rd_addr;
    logic                 key_wr_en;
    logic [AW-1:0]        key_wr_addr;
    logic [KEY_WIDTH-1:0] key_wr_data;
    logic                 fill_wr_en;
    logic [BW-1:0]        fill_wr_addr;
    logic [FW-1:0]        fill_wr_data;
    t_status              res_status;
    logic [CNT_W-1:0]     res_cnt;

    bkm_mod #(
        .BUCKETS   (BUCKETS),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_mod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.load),
        .i_key    (i_key[KEY_WIDTH-1:0]),
        .o_done   (mod_done),
        .o_bucket (mod_bkt)
    );

    always_comb begin
        fill_full  = (r_fill_q == FW'(BUCKET_DEPTH));
        fill_inc   = r_fill_q + FW'(1);
        fill_dec   = r_fill_q - FW'(1);
        hit        = r_cmp_vld && (r_key_q == r_key);
        scan_issue = i_cmd.scan && (r_idx < r_fill_q);
        scan_end   = (r_idx == r_fill_q) || ((r_op == OP_REMOVE) && hit);
        sweep_last = (r_sweep == BW'(BUCKETS - 1));
        out_free   = !r_out_vld || i_m_tready;
    end

    // Key memory ports.
    always_comb begin
        key_rd_en   = scan_issue || i_cmd.move_rd;
        key_rd_addr = i_cmd.move_rd ? (r_base + AW'(fill_dec)) : (r_base + AW'(r_idx));
        key_wr_en   = i_cmd.ins_wr || i_cmd.move_wr;
        key_wr_addr = i_cmd.ins_wr ? (r_base + AW'(r_fill_q)) : (r_base + AW'(r_pos));
        key_wr_data = i_cmd.ins_wr ? r_key : r_key_q;
    end

    // Fill memory write port.
    always_comb begin
        fill_wr_en   = i_cmd.sweep || i_cmd.ins_wr || i_cmd.move_wr;
        fill_wr_addr = i_cmd.sweep ? r_sweep : mod_bkt;
        if (i_cmd.sweep) begin
            fill_wr_data = '0;
        end else if (i_cmd.ins_wr) begin
            fill_wr_data = fill_inc;
        end else begin
            fill_wr_data = fill_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (key_wr_en) begin
            key_mem[key_wr_addr] <= key_wr_data;
        end
        if (key_rd_en) begin
            r_key_q <= key_mem[key_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (fill_wr_en) begin
            fill_mem[fill_wr_addr] <= fill_wr_data;
        end
        if (i_cmd.fill_rd) begin
            r_fill_q <= fill_mem[mod_bkt];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
            r_sweep   <= '0;
        end else begin
            r_cmp_vld <= scan_issue;
            if (i_cmd.sweep) begin
                r_sweep <= sweep_last ? '0 : (r_sweep + BW'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_key <= i_key[KEY_WIDTH-1:0];
        end
        if (i_cmd.fill_rd) begin
            r_base <= AW'(mod_bkt) * AW'(BUCKET_DEPTH);
        end
        if (i_cmd.scan_init) begin
            r_idx   <= '0;
            r_found <= 1'b0;
            r_cnt   <= '0;
        end else if (i_cmd.scan) begin
            if (scan_issue) begin
                r_idx     <= r_idx + FW'(1);
                r_cmp_idx <= r_idx[IW-1:0];
            end
            if (hit) begin
                if (!r_found) begin
                    r_pos <= r_cmp_idx;
                end
                r_found <= 1'b1;
                if (r_cnt != CNT_MAX) begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end
        end
    end

    always_comb begin
        case (r_op)
            OP_INSERT: res_status = fill_full ? ST_FULL : ST_OK;
            OP_REMOVE: res_status = r_found ? ST_OK : ST_NOT_FOUND;
            default:   res_status = ST_OK;
        endcase
        res_cnt = (r_op == OP_COUNT) ? r_cnt : '0;
    end

    // Result register: holds one result while the next item is taken in.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_out_status <= res_status;
            r_out_cnt    <= res_cnt;
        end
    end

    assign o_m_tvalid    = r_out_vld;
    assign o_status      = r_out_status;
    assign o_match_count = r_out_cnt;

    assign o_sts.op         = r_op;
    assign o_sts.mod_done   = mod_done;
    assign o_sts.fill_full  = fill_full;
    assign o_sts.scan_end   = scan_end;
    assign o_sts.found      = r_found;
    assign o_sts.out_free   = out_free;
    assign o_sts.sweep_last = sweep_last;

    `BKM_ASSERT(a_cmp_in_bucket, i_clk, i_rst_n, r_cmp_vld |-> (FW'(r_cmp_idx) < r_fill_q), "compared slot beyond bucket fill")
    `BKM_ASSERT(a_ins_room, i_clk, i_rst_n, i_cmd.ins_wr |-> !fill_full, "insert write into a full bucket")
    `BKM_ASSERT(a_res_slot, i_clk, i_rst_n, i_cmd.res_load |-> out_free, "result overwrites a pending result")
    `BKM_ASSERT(a_move_found, i_clk, i_rst_n, i_cmd.move_wr |-> (r_found && $past(i_cmd.move_rd)), "move write without a found key")

endmodule

>>> hdl/bkm_ctrl.sv
// Controller state machine of the bucketed key multiset.
// Depends on bkm_pkg; drives the datapath commands from its status.
module bkm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  bkm_pkg::t_dp_sts i_sts,
    output bkm_pkg::t_dp_cmd o_cmd
);
    import bkm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (i_sts.sweep_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_s_tvalid) n_state = S_HASH;
            end
            S_HASH: begin
                if (i_sts.mod_done) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                case (i_sts.op)
                    OP_INSERT:          n_state = S_DONE;
                    OP_REMOVE, OP_COUNT: n_state = S_SCAN;
                    default:            n_state = S_CLEAR;
                endcase
            end
            S_SCAN: begin
                if (i_sts.scan_end) begin
                    n_state = (i_sts.op == OP_REMOVE) ? S_MOVE_RD : S_DONE;
                end
            end
            S_MOVE_RD: begin
                n_state = i_sts.found ? S_MOVE_WR : S_DONE;
            end
            S_MOVE_WR: begin
                n_state = S_DONE;
            end
            S_CLEAR: begin
                if (i_sts.sweep_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_INIT, S_CLEAR: begin
                o_cmd.sweep = 1'b1;
            end
            S_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            S_HASH: begin
                o_cmd.fill_rd = i_sts.mod_done;
            end
            S_DISPATCH: begin
                o_cmd.ins_wr    = (i_sts.op == OP_INSERT) && !i_sts.fill_full;
                o_cmd.scan_init = i_sts.op inside {OP_REMOVE, OP_COUNT};
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            S_MOVE_RD: begin
                o_cmd.move_rd = i_sts.found;
            end
            S_MOVE_WR: begin
                o_cmd.move_wr = 1'b1;
            end
            S_DONE: begin
                o_cmd.res_load = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

>>> hdl/bucketed_key_multiset.sv
// Top level of the bucketed key multiset: controller plus datapath.
// Depends on bkm_pkg, bkm_ctrl, bkm_dpath (and bkm_mod below it).
//
//   channel  dir  handshake           payload
//   s_*      in   s_tvalid/s_tready   s_tuser = operation, s_tdata = key
//   m_*      out  m_tvalid/m_tready   m_tdata = status, match_count
//
// The bucket scan reads one stored key per cycle through the single key-memory
// read port, over the filled slots of the bucket (a remove stops at its match).
// With a power-of-two BUCKETS the key modulo unit takes the low key bits; other
// BUCKETS values fold one 16-bit key chunk at a time through a reciprocal
// multiply, in a multiply step and a remainder step per chunk.
// After reset the fill memory is swept to zero, bucket by bucket; no item
// is taken until the sweep ends. The clear operation runs the same sweep.
// One result waits in the output register; a stalled m_tready holds it and
// the next item is still accepted, finishing only once the slot frees.
module bucketed_key_multiset #(
    parameter int BUCKETS      = 1024,
    parameter int BUCKET_DEPTH = 8,
    parameter int KEY_WIDTH    = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Input item
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [bkm_pkg::KEY_BITS-1:0] s_tdata,  // [63:0] key
    input  logic [1:0]                   s_tuser,  // [1:0] operation
    // Result item
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [bkm_pkg::OUT_W-1:0]    m_tdata   // [1:0] status, [5:2] match_count, [7:6] zero
);
    import bkm_pkg::*;

    t_dp_cmd          cmd;
    t_dp_sts          sts;
    t_status          status;
    logic [CNT_W-1:0] match_count;

    // Sequence each item: hash, fill read, scan or sweep, write back.
    bkm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Hold the memories, compare logic and the result register.
    bkm_dpath #(
        .BUCKETS      (BUCKETS),
        .BUCKET_DEPTH (BUCKET_DEPTH),
        .KEY_WIDTH    (KEY_WIDTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_op          (t_op'(s_tuser)),
        .i_key         (s_tdata),
        .i_m_tready    (m_tready),
        .o_m_tvalid    (m_tvalid),
        .o_status      (status),
        .o_match_count (match_count)
    );

    // Pack the result fields from the lowest bit up, zero-fill to a byte.
    assign m_tdata = {2'b00, match_count, status};

endmodule
